>>> src/qxmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_pkg
// Types and constants shared by the quad X motor mixer modules.
// ----------------------------------------------------------------------------
package qxmm_pkg;

    // flight state codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FLIGHT = 2'd1;
    localparam logic [1:0] ST_TEST   = 2'd2;

    // pulse-width constants, microseconds
    localparam logic signed [12:0] ALT_CENTER = 13'sd1500;
    localparam logic signed [12:0] BASE_CAP   = 13'sd1800;
    localparam logic signed [13:0] MOTOR_MIN  = 14'sd1100;
    localparam logic signed [13:0] MOTOR_MAX  = 14'sd2000;
    localparam logic signed [11:0] IDLE_PULSE = 12'sd1000;

    localparam logic signed [9:0] OFFSET_RESET = 10'sd150;

    // one input transaction
    typedef struct packed {
        logic [1:0]         flight_state;
        logic               altitude_mode;
        logic [10:0]        rx_throttle;
        logic signed [10:0] pid_pitch;
        logic signed [10:0] pid_roll;
        logic signed [10:0] pid_yaw;
        logic signed [10:0] pid_altitude;
        logic signed [10:0] pilot_adjust;
    } t_item;

    // four motor pulse widths
    typedef struct packed {
        logic signed [11:0] motor1;
        logic signed [11:0] motor2;
        logic signed [11:0] motor3;
        logic signed [11:0] motor4;
    } t_motors;

endpackage

>>> src/qxmm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_in_if
// Valid/ready channel carrying one control-loop item into the mixer.
// ----------------------------------------------------------------------------
interface qxmm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         flight_state;
    logic               altitude_mode;
    logic [10:0]        rx_throttle;
    logic signed [10:0] pid_pitch;
    logic signed [10:0] pid_roll;
    logic signed [10:0] pid_yaw;
    logic signed [10:0] pid_altitude;
    logic signed [10:0] pilot_adjust;

    modport source (
        output valid, flight_state, altitude_mode, rx_throttle,
               pid_pitch, pid_roll, pid_yaw, pid_altitude, pilot_adjust,
        input  ready
    );

    modport sink (
        input  valid, flight_state, altitude_mode, rx_throttle,
               pid_pitch, pid_roll, pid_yaw, pid_altitude, pilot_adjust,
        output ready
    );
endinterface

>>> src/qxmm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_out_if
// Valid/ready channel carrying the four ESC pulse widths.
// ----------------------------------------------------------------------------
interface qxmm_out_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] motor1_pulse;
    logic signed [11:0] motor2_pulse;
    logic signed [11:0] motor3_pulse;
    logic signed [11:0] motor4_pulse;

    modport source (
        output valid, motor1_pulse, motor2_pulse, motor3_pulse, motor4_pulse,
        input  ready
    );

    modport sink (
        input  valid, motor1_pulse, motor2_pulse, motor3_pulse, motor4_pulse,
        output ready
    );
endinterface

>>> src/qxmm_base.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_base
// Base throttle select and cap, plus the stored base used by test state.
// ----------------------------------------------------------------------------
module qxmm_base (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qxmm_pkg::t_item    i_item,
    input  logic signed [9:0]  i_offset,
    input  logic               i_update,
    output logic signed [11:0] o_base,
    output logic signed [11:0] o_stored
);

    logic signed [12:0] w_rx;
    logic signed [12:0] w_off;
    logic signed [12:0] w_palt;
    logic signed [12:0] w_padj;
    logic signed [12:0] w_sum;
    logic signed [11:0] r_base;

    // sign/zero extend operands to 13 bits
    assign w_rx   = signed'({2'b00, i_item.rx_throttle});
    assign w_off  = {{3{i_offset[9]}}, i_offset};
    assign w_palt = {{2{i_item.pid_altitude[10]}}, i_item.pid_altitude};
    assign w_padj = {{2{i_item.pilot_adjust[10]}}, i_item.pilot_adjust};

    // altitude hold centers on 1500, otherwise follow the receiver
    always_comb begin
        if (i_item.altitude_mode) begin
            w_sum = qxmm_pkg::ALT_CENTER + w_off + w_palt + w_padj;
        end else begin
            w_sum = w_rx + w_off;
        end
    end

    // upper cap only; low values range down to -1060 and fit 12 bits
    always_comb begin
        if (w_sum > qxmm_pkg::BASE_CAP) begin
            o_base = qxmm_pkg::BASE_CAP[11:0];
        end else begin
            o_base = w_sum[11:0];
        end
    end

    // stored base from the last flight transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_update && (i_item.flight_state == qxmm_pkg::ST_FLIGHT)) begin
            r_base <= o_base;
        end
    end

    assign o_stored = r_base;

endmodule

>>> src/qxmm_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_mix
// X-frame motor mix with output clamp, and per-state output select.
// ----------------------------------------------------------------------------
module qxmm_mix (
    input  qxmm_pkg::t_item    i_item,
    input  logic signed [11:0] i_base,
    input  logic signed [11:0] i_stored,
    output qxmm_pkg::t_motors  o_motors
);

    function automatic logic signed [11:0] clamp_motor(input logic signed [13:0] v);
        logic signed [13:0] c;
        begin
            c = v;
            if (c < qxmm_pkg::MOTOR_MIN) c = qxmm_pkg::MOTOR_MIN;
            if (c > qxmm_pkg::MOTOR_MAX) c = qxmm_pkg::MOTOR_MAX;
            return c[11:0];
        end
    endfunction

    logic signed [13:0] w_b;
    logic signed [13:0] w_p;
    logic signed [13:0] w_r;
    logic signed [13:0] w_y;
    logic signed [13:0] w_m1;
    logic signed [13:0] w_m2;
    logic signed [13:0] w_m3;
    logic signed [13:0] w_m4;

    // extend to 14 bits: base +/- three PID terms stays within -4132..4871
    assign w_b = {{2{i_base[11]}}, i_base};
    assign w_p = {{3{i_item.pid_pitch[10]}}, i_item.pid_pitch};
    assign w_r = {{3{i_item.pid_roll[10]}}, i_item.pid_roll};
    assign w_y = {{3{i_item.pid_yaw[10]}}, i_item.pid_yaw};

    // X mix
    assign w_m1 = w_b - w_p + w_r - w_y;
    assign w_m2 = w_b + w_p + w_r + w_y;
    assign w_m3 = w_b + w_p - w_r - w_y;
    assign w_m4 = w_b - w_p - w_r + w_y;

    // output select; the unused code behaves as idle
    always_comb begin
        case (i_item.flight_state)
            qxmm_pkg::ST_FLIGHT: begin
                o_motors.motor1 = clamp_motor(w_m1);
                o_motors.motor2 = clamp_motor(w_m2);
                o_motors.motor3 = clamp_motor(w_m3);
                o_motors.motor4 = clamp_motor(w_m4);
            end
            qxmm_pkg::ST_TEST: begin
                o_motors.motor1 = i_stored;
                o_motors.motor2 = i_stored;
                o_motors.motor3 = i_stored;
                o_motors.motor4 = i_stored;
            end
            default: begin
                o_motors.motor1 = qxmm_pkg::IDLE_PULSE;
                o_motors.motor2 = qxmm_pkg::IDLE_PULSE;
                o_motors.motor3 = qxmm_pkg::IDLE_PULSE;
                o_motors.motor4 = qxmm_pkg::IDLE_PULSE;
            end
        endcase
    end

endmodule

>>> src/quad_x_motor_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_unit
// Quadcopter X-frame motor mixer: four ESC pulse widths per control item.
// ----------------------------------------------------------------------------
// The mixer takes one transaction per clock while the output is not stalled
// and returns one transaction of four pulse widths for each. Each item
// passes the input register, then the result register; all base-throttle
// and mix arithmetic sits between them. Both stages advance together under
// output backpressure, so input ready stays high whenever the output side
// is ready. The user writes the take-off offset via i_cfg_we / i_cfg_wdata
// only while no transaction is in flight; the block does not enforce it.
module quad_x_motor_mixer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_wdata,
    qxmm_in_if.sink    i_in,
    qxmm_out_if.source o_out
);

    qxmm_pkg::t_item    r_item;
    logic               r_item_valid;
    logic signed [9:0]  r_offset;
    qxmm_pkg::t_motors  r_motors;
    logic               r_out_valid;

    qxmm_pkg::t_motors  n_motors;
    logic signed [11:0] w_base;
    logic signed [11:0] w_stored;
    logic               w_advance;
    logic               w_move;

    // pipeline control
    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_move     = r_item_valid && w_advance;
    assign i_in.ready = !r_item_valid || w_advance;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= qxmm_pkg::OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_offset <= signed'(i_cfg_wdata);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_item_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.flight_state  <= i_in.flight_state;
            r_item.altitude_mode <= i_in.altitude_mode;
            r_item.rx_throttle   <= i_in.rx_throttle;
            r_item.pid_pitch     <= i_in.pid_pitch;
            r_item.pid_roll      <= i_in.pid_roll;
            r_item.pid_yaw       <= i_in.pid_yaw;
            r_item.pid_altitude  <= i_in.pid_altitude;
            r_item.pilot_adjust  <= i_in.pilot_adjust;
        end
    end

    qxmm_base u_base (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r_item),
        .i_offset (r_offset),
        .i_update (w_move),
        .o_base   (w_base),
        .o_stored (w_stored)
    );

    qxmm_mix u_mix (
        .i_item   (r_item),
        .i_base   (w_base),
        .i_stored (w_stored),
        .o_motors (n_motors)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_motors <= n_motors;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.motor1_pulse = r_motors.motor1;
    assign o_out.motor2_pulse = r_motors.motor2;
    assign o_out.motor3_pulse = r_motors.motor3;
    assign o_out.motor4_pulse = r_motors.motor4;

endmodule

>>> src/qxmm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_checker
// Port-level assertions for the motor mixer, bound to the top level.
// ----------------------------------------------------------------------------
module qxmm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [11:0] i_m1,
    input logic signed [11:0] i_m2,
    input logic signed [11:0] i_m3,
    input logic signed [11:0] i_m4
);

    // a stalled output transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // a stalled output transaction keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_m1) && $stable(i_m2) && $stable(i_m3) && $stable(i_m4))
        else $error("output payload changed while stalled");

    // a ready output side never stalls the input
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output ready");

    // mixed outputs are clamped; idle and test outputs are all equal
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_m1 == i_m2) && (i_m2 == i_m3) && (i_m3 == i_m4)) ||
            ((i_m1 >= 12'sd1100) && (i_m1 <= 12'sd2000) &&
             (i_m2 >= 12'sd1100) && (i_m2 <= 12'sd2000) &&
             (i_m3 >= 12'sd1100) && (i_m3 <= 12'sd2000) &&
             (i_m4 >= 12'sd1100) && (i_m4 <= 12'sd2000)))
        else $error("motor pulse out of clamp range");

endmodule

bind quad_x_motor_mixer_unit qxmm_checker u_qxmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_m1        (o_out.motor1_pulse),
    .i_m2        (o_out.motor2_pulse),
    .i_m3        (o_out.motor3_pulse),
    .i_m4        (o_out.motor4_pulse)
);

>>> tb/quad_x_motor_mixer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_unit_test
// Self-checking bench for the quad X motor mixer.
// ----------------------------------------------------------------------------
// A directed table covers reset state, idle and unused state codes, base
// throttle capping, motor clamping on every mix term and negative base
// values shown in test state. Random traffic follows in several phases, each
// with its own take-off offset (both extremes included). Every accepted input
// transaction runs through a local mixer model. Each output transaction is
// compared against the oldest queued motor set. Both handshake sides idle at
// random; one phase runs back to back, one has a long output stall.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_unit_test;

    // state code with no meaning in the block, handled as idle
    localparam logic [1:0] ST_UNUSED = 2'd3;

    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 140;
    localparam int HOLD_CYCLES   = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        bit                known;
        qxmm_pkg::t_motors want;
    } t_typed;

    typedef struct {
        qxmm_pkg::t_item   it;
        bit                known;
        qxmm_pkg::t_motors want;
    } t_row;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [9:0] cfg_wdata;

    qxmm_in_if  in_ch ();
    qxmm_out_if out_ch ();

    quad_x_motor_mixer_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // model state
    int                 offset_model = qxmm_pkg::OFFSET_RESET;
    logic signed [11:0] base_model   = '0;

    qxmm_pkg::t_motors expected_motors [$];
    t_typed            typed_results   [$];
    t_row              corner_rows     [$];

    bit burst_mode   = 1'b0;
    bit hold_request = 1'b0;

    int items_sent      = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int orphan_count    = 0;
    int offsets_written = 0;

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // mixer model
    // ------------------------------------------------------------------
    function automatic logic signed [11:0] clamp_pulse(input int v);
        if (v < qxmm_pkg::MOTOR_MIN) v = qxmm_pkg::MOTOR_MIN;
        if (v > qxmm_pkg::MOTOR_MAX) v = qxmm_pkg::MOTOR_MAX;
        return v[11:0];
    endfunction

    function automatic qxmm_pkg::t_motors same_pulse(input int v);
        qxmm_pkg::t_motors m;
        m.motor1 = v[11:0];
        m.motor2 = v[11:0];
        m.motor3 = v[11:0];
        m.motor4 = v[11:0];
        return m;
    endfunction

    // computes the four pulses and updates the stored base throttle
    function automatic qxmm_pkg::t_motors mix_motors(input qxmm_pkg::t_item it);
        int                b;
        int                p;
        int                r;
        int                y;
        qxmm_pkg::t_motors m;
        p = $signed(it.pid_pitch);
        r = $signed(it.pid_roll);
        y = $signed(it.pid_yaw);
        case (it.flight_state)
            qxmm_pkg::ST_FLIGHT: begin
                if (it.altitude_mode)
                    b = qxmm_pkg::ALT_CENTER + offset_model + $signed(it.pid_altitude)
                        + $signed(it.pilot_adjust);
                else
                    b = int'(it.rx_throttle) + offset_model;
                if (b > qxmm_pkg::BASE_CAP) b = qxmm_pkg::BASE_CAP;
                base_model = b[11:0];
                m.motor1 = clamp_pulse(b - p + r - y);
                m.motor2 = clamp_pulse(b + p + r + y);
                m.motor3 = clamp_pulse(b + p - r - y);
                m.motor4 = clamp_pulse(b - p - r + y);
            end
            qxmm_pkg::ST_TEST: begin
                m = same_pulse(base_model);
            end
            default: begin
                m = same_pulse(qxmm_pkg::IDLE_PULSE);
            end
        endcase
        return m;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic qxmm_pkg::t_item make_item(input logic [1:0] st, input bit alt,
                                                  input int rx, input int p, input int r,
                                                  input int y, input int pa, input int pj);
        qxmm_pkg::t_item it;
        it.flight_state  = st;
        it.altitude_mode = alt;
        it.rx_throttle   = rx[10:0];
        it.pid_pitch     = p[10:0];
        it.pid_roll      = r[10:0];
        it.pid_yaw       = y[10:0];
        it.pid_altitude  = pa[10:0];
        it.pilot_adjust  = pj[10:0];
        return it;
    endfunction

    // extremes, values near zero and full range
    function automatic int rand_pid();
        case ($urandom_range(0, 7))
            0:       return -1024;
            1:       return 1023;
            2, 3:    return int'($urandom_range(0, 400)) - 200;
            default: return int'($urandom_range(0, 2047)) - 1024;
        endcase
    endfunction

    function automatic int rand_rx();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 2047;
            2, 3, 4: return int'($urandom_range(900, 1900));
            default: return int'($urandom_range(0, 2047));
        endcase
    endfunction

    // mostly flight, some test, a little idle and unused state
    function automatic qxmm_pkg::t_item rand_item();
        logic [1:0] st;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)      st = qxmm_pkg::ST_FLIGHT;
        else if (pick < 8) st = qxmm_pkg::ST_TEST;
        else if (pick < 9) st = qxmm_pkg::ST_IDLE;
        else               st = ST_UNUSED;
        return make_item(st, $urandom_range(0, 1), rand_rx(), rand_pid(),
                         rand_pid(), rand_pid(), rand_pid(), rand_pid());
    endfunction

    function automatic int pick_gap();
        if (burst_mode) return 0;
        return $urandom_range(0, 8);
    endfunction

    // offer one transaction, return at the edge where it is taken
    task automatic send_item(input qxmm_pkg::t_item it, input bit known,
                             input qxmm_pkg::t_motors want);
        int gap;
        t_typed tag;
        gap = pick_gap();
        tag.known = known;
        tag.want  = want;
        typed_results.push_back(tag);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.flight_state  <= it.flight_state;
        in_ch.altitude_mode <= it.altitude_mode;
        in_ch.rx_throttle   <= it.rx_throttle;
        in_ch.pid_pitch     <= it.pid_pitch;
        in_ch.pid_roll      <= it.pid_roll;
        in_ch.pid_yaw       <= it.pid_yaw;
        in_ch.pid_altitude  <= it.pid_altitude;
        in_ch.pilot_adjust  <= it.pilot_adjust;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_motors.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_offset(input logic [9:0] bits);
        cfg_we    <= 1'b1;
        cfg_wdata <= bits;
        @(posedge clk);
        cfg_we       <= 1'b0;
        offset_model = $signed(bits);
        offsets_written++;
    endtask

    // ------------------------------------------------------------------
    // input side: accepted transactions feed the model
    // ------------------------------------------------------------------
    always @(posedge clk) begin : in_accept
        qxmm_pkg::t_item   it;
        qxmm_pkg::t_motors mixed;
        t_typed            tag;
        if (rst_n && in_ch.valid && in_ch.ready) begin
            it.flight_state  = in_ch.flight_state;
            it.altitude_mode = in_ch.altitude_mode;
            it.rx_throttle   = in_ch.rx_throttle;
            it.pid_pitch     = in_ch.pid_pitch;
            it.pid_roll      = in_ch.pid_roll;
            it.pid_yaw       = in_ch.pid_yaw;
            it.pid_altitude  = in_ch.pid_altitude;
            it.pilot_adjust  = in_ch.pilot_adjust;
            mixed = mix_motors(it);
            tag   = typed_results.pop_front();
            expected_motors.push_back(tag.known ? tag.want : mixed);
        end
    end

    // ------------------------------------------------------------------
    // output side: compare each result with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin : out_check
        qxmm_pkg::t_motors got;
        qxmm_pkg::t_motors want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.motor1 = out_ch.motor1_pulse;
            got.motor2 = out_ch.motor2_pulse;
            got.motor3 = out_ch.motor3_pulse;
            got.motor4 = out_ch.motor4_pulse;
            if (expected_motors.size() == 0) begin
                orphan_count++;
                if (orphan_count + mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result %0d %0d %0d %0d", $realtime,
                             got.motor1, got.motor2, got.motor3, got.motor4);
            end else begin
                want = expected_motors.pop_front();
                results_checked++;
                if (got.motor1 !== want.motor1 || got.motor2 !== want.motor2 ||
                    got.motor3 !== want.motor3 || got.motor4 !== want.motor4) begin
                    mismatch_count++;
                    if (orphan_count + mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result %0d expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 $realtime, results_checked,
                                 want.motor1, want.motor2, want.motor3, want.motor4,
                                 got.motor1, got.motor2, got.motor3, got.motor4);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, one long hold on request
    // ------------------------------------------------------------------
    initial begin : receiver
        int gap;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = pick_gap();
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [9:0]        offset_plan [PHASES];
        qxmm_pkg::t_motors none;
        none = '0;

        in_ch.valid         <= 1'b0;
        in_ch.flight_state  <= qxmm_pkg::ST_IDLE;
        in_ch.altitude_mode <= 1'b0;
        in_ch.rx_throttle   <= '0;
        in_ch.pid_pitch     <= '0;
        in_ch.pid_roll      <= '0;
        in_ch.pid_yaw       <= '0;
        in_ch.pid_altitude  <= '0;
        in_ch.pilot_adjust  <= '0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        rst_n               <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners, reset offset of 150
        corner_rows = '{
            '{make_item(qxmm_pkg::ST_TEST, 0, 0, 0, 0, 0, 0, 0), 1, same_pulse(0)},
            '{make_item(qxmm_pkg::ST_IDLE, 1, 2047, -1024, -1024, -1024, -1024, -1024),
              1, same_pulse(1000)},
            '{make_item(ST_UNUSED, 1, 2047, 1023, 1023, 1023, 1023, 1023),
              1, same_pulse(1000)},
            '{make_item(qxmm_pkg::ST_FLIGHT, 0, 1000, 0, 0, 0, 0, 0),
              1, same_pulse(1150)},
            '{make_item(qxmm_pkg::ST_TEST, 0, 0, 0, 0, 0, 0, 0), 1, same_pulse(1150)},
            '{make_item(qxmm_pkg::ST_FLIGHT, 0, 2047, 0, 0, 0, 0, 0),
              1, same_pulse(1800)},
            '{make_item(qxmm_pkg::ST_FLIGHT, 0, 2047, 1023, 0, 0, 0, 0),
              1, qxmm_pkg::t_motors'{12'sd1100, 12'sd2000, 12'sd2000, 12'sd1100}},
            '{make_item(qxmm_pkg::ST_FLIGHT, 0, 2047, 0, -1024, 0, 0, 0),
              1, qxmm_pkg::t_motors'{12'sd1100, 12'sd1100, 12'sd2000, 12'sd2000}},
            '{make_item(qxmm_pkg::ST_FLIGHT, 0, 2047, 0, 0, 1023, 0, 0),
              1, qxmm_pkg::t_motors'{12'sd1100, 12'sd2000, 12'sd1100, 12'sd2000}},
            '{make_item(qxmm_pkg::ST_FLIGHT, 0, 0, 0, 0, 0, 0, 0), 1, same_pulse(1100)},
            '{make_item(qxmm_pkg::ST_TEST, 0, 0, 0, 0, 0, 0, 0), 1, same_pulse(150)},
            '{make_item(qxmm_pkg::ST_FLIGHT, 1, 2047, 0, 0, 0, 0, 0),
              1, same_pulse(1650)},
            '{make_item(qxmm_pkg::ST_FLIGHT, 1, 0, 0, 0, 0, 1023, 1023),
              1, same_pulse(1800)},
            '{make_item(qxmm_pkg::ST_FLIGHT, 1, 0, 0, 0, 0, -1024, -1024),
              1, same_pulse(1100)},
            '{make_item(qxmm_pkg::ST_TEST, 0, 0, 0, 0, 0, 0, 0), 1, same_pulse(-398)},
            '{make_item(ST_UNUSED, 0, 0, 0, 0, 0, 0, 0), 1, same_pulse(1000)},
            '{make_item(qxmm_pkg::ST_TEST, 1, 2047, 0, 0, 0, 0, 0), 1, same_pulse(-398)},
            '{make_item(qxmm_pkg::ST_IDLE, 0, 1500, 0, 0, 0, 0, 0), 1, same_pulse(1000)},
            '{make_item(qxmm_pkg::ST_TEST, 0, 0, 0, 0, 0, 0, 0), 1, same_pulse(-398)},
            '{make_item(qxmm_pkg::ST_FLIGHT, 0, 1300, 120, -75, 33, 0, 0), 0, none},
            '{make_item(qxmm_pkg::ST_FLIGHT, 1, 900, -1024, 1023, -1024, -300, 250),
              0, none},
            '{make_item(qxmm_pkg::ST_TEST, 0, 0, 0, 0, 0, 0, 0), 0, none},
            '{make_item(qxmm_pkg::ST_FLIGHT, 0, 1500, -1, -1, -1, -1, -1), 0, none}
        };
        foreach (corner_rows[i])
            send_item(corner_rows[i].it, corner_rows[i].known, corner_rows[i].want);

        // random phases, each under its own take-off offset
        offset_plan[0] = 10'h200;           // most negative
        offset_plan[1] = 10'h1FF;           // most positive
        offset_plan[2] = 10'h000;
        offset_plan[3] = 10'h3FF;           // minus one
        offset_plan[4] = 10'($urandom_range(0, 1023));
        offset_plan[5] = 10'd150;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_results_drained();
            write_offset(offset_plan[ph]);
            burst_mode = (ph == 2);
            // lowest altitude-hold base, then read it back in test state
            send_item(make_item(qxmm_pkg::ST_FLIGHT, 1, rand_rx(), rand_pid(), rand_pid(),
                                rand_pid(), -1024, -1024), 0, none);
            send_item(make_item(qxmm_pkg::ST_TEST, 0, 0, 0, 0, 0, 0, 0), 0, none);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 3 && i == 20) hold_request = 1'b1;
                send_item(rand_item(), 0, none);
            end
        end
        burst_mode = 1'b0;

        wait_results_drained();
        repeat (8) @(posedge clk);

        $display("Covered %0d transactions in, %0d results checked, %0d offset settings.",
                 items_sent, results_checked, offsets_written);
        $display("Directed corners, random flight/test/idle traffic, %s",
                 "one back-to-back phase, one long output stall.");
        if (mismatch_count == 0 && orphan_count == 0) begin
            $display("quad_x_motor_mixer_unit regression: pass");
        end else begin
            $display("%0d mismatches, %0d unexpected results", mismatch_count, orphan_count);
            $display("quad_x_motor_mixer_unit regression: fail");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #400000;
        $display("timeout: %0d transactions sent, %0d results checked",
                 items_sent, results_checked);
        $display("quad_x_motor_mixer_unit regression: fail");
        $finish;
    end

endmodule
